[sv/ole_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // request operation codes
    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_DEL_AT  = 3'd2;
    localparam logic [2:0] OP_DEL_VAL = 3'd3;
    localparam logic [2:0] OP_FIND    = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
        logic signed [15:0] position;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  found_index;
        logic [10:0] entry_total;
    } t_rsp;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_SET,
        CM_REMOVE
    } t_cell_mode;

    // broadcast to every cell of the row
    typedef struct packed {
        t_cell_mode         mode;
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] word;
    } t_cell_cmd;

endpackage
`default_nettype wire

[sv/ordered_list_engine_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Ordered list of signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel   | handshake        | payload
//  ----------+------------------+----------------------------------------
//  request   | start / busy     | i_req  (operation, value, position)
//  result    | o_done (strobe)  | o_rsp  (status, found_index, entry_total)
//
//  Every item passes through the accept cycle, where every cell compares
//  its word against the request value and registers a match bit, then the
//  execute cycle, where the first match is picked and all cells shift,
//  load or hold together. The result strobe comes the cycle after execute,
//  in the same cycle the next item may be accepted.
//  busy is high during execute only. Synchronous active-low reset clears
//  the entry count and control; cell words are not cleared (only entries
//  below the count are ever read). The result cannot be stalled.
// ----------------------------------------------------------------------------
module ordered_list_engine_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire ole_pkg::t_req i_req,
    output logic               busy,
    output logic               o_done,
    output ole_pkg::t_rsp      o_rsp
);

    localparam int DEPTH = ole_pkg::DEPTH;
    localparam int IDX_W = ole_pkg::IDX_W;
    localparam int CNT_W = ole_pkg::CNT_W;

    ole_pkg::t_state     r_state;
    ole_pkg::t_state     n_state;
    ole_pkg::t_req       r_req;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_done;
    ole_pkg::t_rsp       r_rsp;
    ole_pkg::t_rsp       n_rsp;
    ole_pkg::t_cell_cmd  cell_cmd;
    logic                accept;

    logic signed [31:0]  cell_word  [DEPTH];
    logic [DEPTH-1:0]    cell_match;
    logic                hit_any;
    logic [IDX_W-1:0]    hit_index;

    // position decode
    logic [15:0]         cnt16;
    logic                pos_neg;
    logic                pos_ge;
    logic                in_range;
    logic                full;
    logic [IDX_W-1:0]    ins_idx;

    assign accept = start && (r_state == ole_pkg::S_IDLE);

    // ---------------- cell row ----------------
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [31:0] left_w;
        logic signed [31:0] right_w;
        if (k == 0) begin : g_lo
            assign left_w = cell_word[k];
        end else begin : g_lo_n
            assign left_w = cell_word[k-1];
        end
        if (k == DEPTH - 1) begin : g_hi
            assign right_w = cell_word[k];
        end else begin : g_hi_n
            assign right_w = cell_word[k+1];
        end
        ole_cell u_cell (
            .i_clk      (i_clk),
            .i_slot     (IDX_W'(k)),
            .i_count    (r_count),
            .i_probe_en (accept),
            .i_probe    (i_req.value),
            .i_cmd      (cell_cmd),
            .i_left     (left_w),
            .i_right    (right_w),
            .o_word     (cell_word[k]),
            .o_match    (cell_match[k])
        );
    end

    ole_first u_first (
        .i_match (cell_match),
        .o_any   (hit_any),
        .o_index (hit_index)
    );

    // ---------------- request decode ----------------
    assign cnt16    = 16'(r_count);
    assign pos_neg  = r_req.position[15];
    assign pos_ge   = $unsigned(r_req.position) >= cnt16;
    assign in_range = !pos_neg && !pos_ge;
    assign full     = (r_count == CNT_W'(DEPTH));

    // insert clamps: at or below zero prepends, at or past the end appends
    always_comb begin
        if (pos_neg) begin
            ins_idx = '0;
        end else if (pos_ge) begin
            ins_idx = r_count[IDX_W-1:0];
        end else begin
            ins_idx = r_req.position[IDX_W-1:0];
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ole_pkg::S_IDLE: begin
                if (start) begin
                    n_state = ole_pkg::S_EXEC;
                end
            end
            ole_pkg::S_EXEC: begin
                n_state = ole_pkg::S_IDLE;
            end
            default: begin
                n_state = ole_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- execute outputs ----------------
    always_comb begin
        cell_cmd.mode = ole_pkg::CM_HOLD;
        cell_cmd.idx  = '0;
        cell_cmd.word = r_req.value;
        n_count       = r_count;
        n_rsp.status      = ole_pkg::ST_MISS;
        n_rsp.found_index = '0;
        if (r_state == ole_pkg::S_EXEC) begin
            unique case (r_req.operation)
                ole_pkg::OP_INSERT: begin
                    if (full) begin
                        n_rsp.status = ole_pkg::ST_FULL;
                    end else begin
                        n_rsp.status  = ole_pkg::ST_OK;
                        cell_cmd.mode = ole_pkg::CM_INSERT;
                        cell_cmd.idx  = ins_idx;
                        n_count       = r_count + CNT_W'(1);
                    end
                end
                ole_pkg::OP_SET: begin
                    if (in_range) begin
                        n_rsp.status  = ole_pkg::ST_OK;
                        cell_cmd.mode = ole_pkg::CM_SET;
                        cell_cmd.idx  = r_req.position[IDX_W-1:0];
                    end
                end
                ole_pkg::OP_DEL_AT: begin
                    if (in_range) begin
                        n_rsp.status  = ole_pkg::ST_OK;
                        cell_cmd.mode = ole_pkg::CM_REMOVE;
                        cell_cmd.idx  = r_req.position[IDX_W-1:0];
                        n_count       = r_count - CNT_W'(1);
                    end
                end
                ole_pkg::OP_DEL_VAL: begin
                    if (hit_any) begin
                        n_rsp.status  = ole_pkg::ST_OK;
                        cell_cmd.mode = ole_pkg::CM_REMOVE;
                        cell_cmd.idx  = hit_index;
                        n_count       = r_count - CNT_W'(1);
                    end
                end
                ole_pkg::OP_FIND: begin
                    if (hit_any) begin
                        n_rsp.status      = ole_pkg::ST_OK;
                        n_rsp.found_index = 10'(hit_index);
                    end
                end
                default: begin
                    n_rsp.status = ole_pkg::ST_MISS;
                end
            endcase
        end
        n_rsp.entry_total = 11'(n_count);
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ole_pkg::S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == ole_pkg::S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_state == ole_pkg::S_EXEC) begin
            r_rsp <= n_rsp;
        end
    end

    assign busy   = (r_state == ole_pkg::S_EXEC);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTH
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not enter execute");

    a_exec_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (!busy && o_done))
        else $error("execute not followed by result strobe");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_count_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(busy))
        else $error("entry count changed outside execute");
`endif

endmodule
`default_nettype wire

[sv/ole_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_cell
// One slot of the list: holds a word, compares it, shifts with neighbors.
// ----------------------------------------------------------------------------
module ole_cell (
    input  wire logic                        i_clk,
    input  wire logic [ole_pkg::IDX_W-1:0]   i_slot,
    input  wire logic [ole_pkg::CNT_W-1:0]   i_count,
    input  wire logic                        i_probe_en,
    input  wire logic signed [31:0]          i_probe,
    input  wire ole_pkg::t_cell_cmd          i_cmd,
    input  wire logic signed [31:0]          i_left,
    input  wire logic signed [31:0]          i_right,
    output logic signed [31:0]               o_word,
    output logic                             o_match
);

    logic signed [31:0] r_word;
    logic signed [31:0] n_word;
    logic               r_match;
    logic               in_list;

    assign in_list = ole_pkg::CNT_W'(i_slot) < i_count;

    always_comb begin
        n_word = r_word;
        case (i_cmd.mode)
            ole_pkg::CM_INSERT: begin
                if (i_slot > i_cmd.idx) begin
                    n_word = i_left;
                end else if (i_slot == i_cmd.idx) begin
                    n_word = i_cmd.word;
                end
            end
            ole_pkg::CM_SET: begin
                if (i_slot == i_cmd.idx) begin
                    n_word = i_cmd.word;
                end
            end
            ole_pkg::CM_REMOVE: begin
                if (i_slot >= i_cmd.idx) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (i_probe_en) begin
            r_match <= in_list && (r_word == i_probe);
        end
    end

    assign o_word  = r_word;
    assign o_match = r_match;

endmodule
`default_nettype wire

[sv/ole_first.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_first
// Lowest set bit of the match row: presence flag and its index.
// ----------------------------------------------------------------------------
module ole_first (
    input  wire logic [ole_pkg::DEPTH-1:0] i_match,
    output logic                           o_any,
    output logic [ole_pkg::IDX_W-1:0]      o_index
);

    logic [ole_pkg::DEPTH-1:0] lowest;

    // isolate lowest set bit
    assign lowest = i_match & (~i_match + ole_pkg::DEPTH'(1));
    assign o_any  = |i_match;

    always_comb begin
        o_index = '0;
        for (int k = 0; k < ole_pkg::DEPTH; k++) begin
            if (lowest[k]) begin
                o_index = o_index | ole_pkg::IDX_W'(k);
            end
        end
    end

endmodule
`default_nettype wire
